/* hw/rtl/sma_pkg.sv */
package sma_pkg;

	localparam int KIND_W = 4;
	localparam int DATA_W = 32;
	localparam int DEPTH_W = 11;
	localparam int STATUS_W = 2;
	localparam int STACK_DEPTH_DEF = 1024;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam kind_t OP_PUSH = 4'd0;
	localparam kind_t OP_ADD = 4'd1;
	localparam kind_t OP_SUB = 4'd2;
	localparam kind_t OP_MUL = 4'd3;
	localparam kind_t OP_DIV = 4'd4;
	localparam kind_t OP_MAX = 4'd5;
	localparam kind_t OP_MIN = 4'd6;
	localparam kind_t OP_NEG = 4'd7;
	localparam kind_t OP_DUP = 4'd8;
	localparam kind_t OP_SWAP = 4'd9;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_UNDER = 2'd1;
	localparam status_t ST_OVER = 2'd2;
	localparam status_t ST_DIVZ = 2'd3;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic needs_div;
		logic div_done;
	} sts_t;

endpackage

/* hw/rtl/sma_if.sv */
interface sma_in_if;
	import sma_pkg::*;

	logic valid;
	logic ready;
	kind_t kind;
	data_t value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

interface sma_out_if;
	import sma_pkg::*;

	logic valid;
	logic ready;
	data_t top_value;
	depth_t depth;
	status_t status;

	modport source (output valid, output top_value, output depth, output status, input ready);
	modport sink (input valid, input top_value, input depth, input status, output ready);
endinterface

/* hw/rtl/stack_machine_alu.sv */
// Integer stack machine with 32-bit entries. Each item on in_ch carries one
// instruction (kind) and, for a push, its operand (value). Each item yields
// exactly one item on out_ch with the new top of stack, the entry count and a
// status code for underflow, overflow or a zero divisor.
// An instruction is taken when the block is idle and is captured into
// registers; push, add, sub, mul, max, min, neg, dup and swap then reach the
// result register from the execute state, and no new item is taken until then.
// A divide runs through a radix-2 iterative divider of 32 steps and reaches the
// result register from the divide-wait state; that divider sets the worst-case
// rate.
// The second entry is read from the stack memory at acceptance; the top entry
// is held in a register, so each instruction needs one memory read at most.
// A new item is accepted while a result still waits in the output register.
// If the receiver stalls, the finished instruction waits before it updates
// the stack until the output register is free; nothing is lost or repeated.
// Reset empties the stack at once; the memory contents are not cleared.
module stack_machine_alu #(
	parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	sma_in_if.sink in_ch,
	sma_out_if.source out_ch
);
	import sma_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;
	logic out_valid;

	sma_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ch.ready),
		.sts(sts),
		.cmd(cmd)
	);

	sma_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_kind(in_ch.kind),
		.in_value(in_ch.value),
		.out_top_value(out_ch.top_value),
		.out_depth(out_ch.depth),
		.out_status(out_ch.status)
	);

	assign in_ch.ready = in_ready;
	assign out_ch.valid = out_valid;

endmodule

/* hw/rtl/sma_div.sv */
module sma_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input sma_pkg::data_t num,
	input sma_pkg::data_t den,
	output logic done,
	output sma_pkg::data_t quot
);
	import sma_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	logic [DATA_W-1:0] den_mag_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [DATA_W:0] rem_sh;
	logic [DATA_W:0] diff;

	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign diff = rem_sh - {1'b0, den_mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num[DATA_W-1] ? -num : num;
			den_mag_q <= den[DATA_W-1] ? -den : den;
			neg_q <= num[DATA_W-1] ^ den[DATA_W-1];
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -quo_q : quo_q;

endmodule

/* hw/rtl/sma_dp.sv */
module sma_dp #(
	parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input sma_pkg::cmd_t cmd,
	output sma_pkg::sts_t sts,
	input sma_pkg::kind_t in_kind,
	input sma_pkg::data_t in_value,
	output sma_pkg::data_t out_top_value,
	output sma_pkg::depth_t out_depth,
	output sma_pkg::status_t out_status
);
	import sma_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// The top of the stack lives in top_q; the memory holds the entries below it.
	data_t mem [STACK_DEPTH];

	kind_t kind_q;
	data_t value_q;
	data_t top_q;
	data_t sec_q;
	logic [DW-1:0] depth_q;

	data_t top_value_q;
	depth_t depth_out_q;
	status_t status_q;

	logic [DW-1:0] dm1;
	logic [DW-1:0] dm2;
	logic is_push, is_dup, is_neg, is_bin;
	logic under, over, divz, ok;
	data_t alu;
	data_t mul_lo;
	data_t div_quot;
	logic div_done;

	data_t top_n;
	logic [DW-1:0] depth_n;
	status_t status_n;
	logic we;
	logic [AW-1:0] waddr;
	logic [DW+DEPTH_W-1:0] depth_wide;

	assign dm1 = depth_q - DW'(1);
	assign dm2 = depth_q - DW'(2);

	assign is_push = kind_q == OP_PUSH;
	assign is_dup = kind_q == OP_DUP;
	assign is_neg = kind_q == OP_NEG;
	assign is_bin = (kind_q >= OP_ADD && kind_q <= OP_MIN) || kind_q == OP_SWAP;

	assign under = ((is_dup || is_neg) && depth_q == '0) || (is_bin && depth_q < DW'(2));
	assign over = (is_push || is_dup) && !under && depth_q == DW'(STACK_DEPTH);
	assign divz = kind_q == OP_DIV && !under && sec_q == '0;
	assign ok = !under && !over && !divz;

	assign mul_lo = top_q * sec_q;

	sma_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(top_q),
		.den(sec_q),
		.done(div_done),
		.quot(div_quot)
	);

	assign sts.needs_div = kind_q == OP_DIV && ok;
	assign sts.div_done = div_done;

	always_comb begin
		case (kind_q)
			OP_ADD: alu = top_q + sec_q;
			OP_SUB: alu = top_q - sec_q;
			OP_MUL: alu = mul_lo;
			OP_DIV: alu = div_quot;
			OP_MAX: alu = (sec_q < top_q) ? top_q : sec_q;
			OP_MIN: alu = (top_q < sec_q) ? top_q : sec_q;
			default: alu = top_q;
		endcase
	end

	always_comb begin
		top_n = top_q;
		depth_n = depth_q;
		we = 1'b0;
		waddr = dm1[AW-1:0];
		if (ok) begin
			case (kind_q) inside
				OP_PUSH: begin
					top_n = value_q;
					depth_n = depth_q + DW'(1);
					we = depth_q != '0;
				end
				OP_DUP: begin
					depth_n = depth_q + DW'(1);
					we = 1'b1;
				end
				OP_NEG: top_n = -top_q;
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN: begin
					top_n = alu;
					depth_n = dm1;
				end
				OP_SWAP: begin
					top_n = sec_q;
					we = 1'b1;
					waddr = dm2[AW-1:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (under)
			status_n = ST_UNDER;
		else if (over)
			status_n = ST_OVER;
		else if (divz)
			status_n = ST_DIVZ;
		else
			status_n = ST_OK;
	end

	assign depth_wide = {{DEPTH_W{1'b0}}, depth_n};

	always_ff @(posedge clk) begin
		if (cmd.capture)
			sec_q <= mem[dm2[AW-1:0]];
		if (cmd.commit && we)
			mem[waddr] <= top_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			value_q <= in_value;
		end
		if (cmd.commit) begin
			top_q <= top_n;
			top_value_q <= (depth_n != '0) ? top_n : '0;
			depth_out_q <= depth_wide[DEPTH_W-1:0];
			status_q <= status_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			depth_q <= '0;
		else if (cmd.commit)
			depth_q <= depth_n;
	end

	assign out_top_value = top_value_q;
	assign out_depth = depth_out_q;
	assign out_status = status_q;

endmodule

/* hw/rtl/sma_ctrl.sv */
module sma_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input sma_pkg::sts_t sts,
	output sma_pkg::cmd_t cmd
);
	import sma_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIVW = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.needs_div) begin
					cmd.div_start = 1'b1;
					state_n = S_DIVW;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_DIVW: begin
				if (sts.div_done && out_free) begin
					cmd.commit = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/sma_check.sv */
module sma_check #(
	parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input sma_pkg::data_t out_top_value,
	input sma_pkg::depth_t out_depth,
	input sma_pkg::status_t out_status
);
	import sma_pkg::*;

	localparam logic [31:0] FULL32 = 32'(STACK_DEPTH);
	localparam depth_t FULL_DEPTH = FULL32[DEPTH_W-1:0];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_top_value) && $stable(out_depth)
			&& $stable(out_status))
		else $error("stalled result item changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is executing");

	a_under_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_UNDER |-> out_depth < depth_t'(2))
		else $error("underflow reported with two or more entries");

	a_over_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_OVER |-> out_depth == FULL_DEPTH)
		else $error("overflow reported on a stack that is not full");

endmodule

bind stack_machine_alu sma_check #(
	.STACK_DEPTH(STACK_DEPTH)
) u_sma_check (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_top_value(out_ch.top_value),
	.out_depth(out_ch.depth),
	.out_status(out_ch.status)
);

/* sim/tb_stack_machine_alu.sv */
module tb_stack_machine_alu;
	import sma_pkg::*;

	localparam int STACK_ENTRIES = STACK_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_FROM = 400;
	localparam int CALM_TO = 560;

	typedef struct {
		logic pause;
		kind_t kind;
		data_t value;
	} instr_t;

	typedef struct {
		data_t top_value;
		depth_t depth;
		status_t status;
	} stack_view_t;

	logic clk = 1'b0;
	logic arst_n;

	sma_in_if in_ch ();
	sma_out_if out_ch ();

	stack_machine_alu DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #5 clk = ~clk;

	instr_t pending_q[$];
	stack_view_t view_q[$];
	logic [31:0] stack_mem [STACK_ENTRIES];
	int unsigned stack_cnt;
	int n_accepted;
	int errors;
	int cycles;
	int hold_left;
	logic hold_done;

	function automatic stack_view_t step_stack(kind_t op, data_t arg);
		stack_view_t r;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		int unsigned d;
		d = stack_cnt;
		r.status = ST_OK;
		case (op)
			OP_PUSH, OP_DUP: begin
				if (op == OP_DUP && d < 1) begin
					r.status = ST_UNDER;
				end else if (d >= STACK_ENTRIES) begin
					r.status = ST_OVER;
				end else begin
					if (op == OP_PUSH) begin
						stack_mem[d] = arg;
					end else begin
						stack_mem[d] = stack_mem[d-1];
					end
					stack_cnt = d + 1;
				end
			end
			OP_NEG: begin
				if (d < 1) begin
					r.status = ST_UNDER;
				end else begin
					stack_mem[d-1] = -stack_mem[d-1];
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN, OP_SWAP: begin
				if (d < 2) begin
					r.status = ST_UNDER;
				end else begin
					a = stack_mem[d-1];
					b = stack_mem[d-2];
					q = '0;
					case (op)
						OP_ADD: q = a + b;
						OP_SUB: q = a - b;
						OP_MUL: q = a * b;
						OP_DIV: begin
							if (b == 0) begin
								r.status = ST_DIVZ;
							end else begin
								ma = a[31] ? -a : a;
								mb = b[31] ? -b : b;
								q = ma / mb;
								if (a[31] != b[31]) begin
									q = -q;
								end
							end
						end
						OP_MAX: q = ($signed(b) < $signed(a)) ? a : b;
						OP_MIN: q = ($signed(a) < $signed(b)) ? a : b;
						default: begin
							stack_mem[d-2] = a;
							stack_mem[d-1] = b;
						end
					endcase
					if (op != OP_SWAP && r.status == ST_OK) begin
						stack_mem[d-2] = q;
						stack_cnt = d - 1;
					end
				end
			end
			default: ;
		endcase
		r.top_value = (stack_cnt > 0) ? data_t'(stack_mem[stack_cnt-1]) : data_t'(0);
		r.depth = depth_t'(stack_cnt);
		return r;
	endfunction

	function automatic data_t pick_value();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			return data_t'($urandom);
		end else if (sel < 70) begin
			return data_t'($urandom_range(0, 16) - 8);
		end else begin
			case ($urandom_range(0, 4))
				0: return data_t'(32'h8000_0000);
				1: return data_t'(32'h7fff_ffff);
				2: return data_t'(0);
				3: return data_t'(-1);
				default: return data_t'(1);
			endcase
		end
	endfunction

	task automatic queue_op(kind_t op, data_t arg);
		instr_t it;
		it.pause = 1'b0;
		it.kind = op;
		it.value = arg;
		pending_q.push_back(it);
	endtask

	task automatic queue_random_ops(int count);
		int sel;
		instr_t it;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 2) begin
				it.pause = 1'b1;
				it.kind = OP_PUSH;
				it.value = '0;
				pending_q.push_back(it);
			end
			sel = $urandom_range(0, 99);
			if (sel < 38) queue_op(OP_PUSH, pick_value());
			else if (sel < 46) queue_op(OP_DUP, pick_value());
			else if (sel < 52) queue_op(OP_ADD, pick_value());
			else if (sel < 58) queue_op(OP_SUB, pick_value());
			else if (sel < 64) queue_op(OP_MUL, pick_value());
			else if (sel < 72) queue_op(OP_DIV, pick_value());
			else if (sel < 78) queue_op(OP_MAX, pick_value());
			else if (sel < 84) queue_op(OP_MIN, pick_value());
			else if (sel < 90) queue_op(OP_NEG, pick_value());
			else if (sel < 97) queue_op(OP_SWAP, pick_value());
			else queue_op(kind_t'($urandom_range(10, 15)), pick_value());
		end
	endtask

	function automatic logic calm();
		return n_accepted >= CALM_FROM && n_accepted < CALM_TO;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_p
		logic next_valid;
		kind_t next_kind;
		data_t next_value;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.kind <= OP_PUSH;
			in_ch.value <= '0;
			n_accepted <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				view_q.push_back(step_stack(in_ch.kind, in_ch.value));
				n_accepted <= n_accepted + 1;
			end
			if (!in_ch.valid || in_ch.ready) begin
				next_valid = 1'b0;
				next_kind = in_ch.kind;
				next_value = in_ch.value;
				if (pending_q.size() != 0 && pending_q[0].pause) begin
					if (view_q.size() == 0) begin
						void'(pending_q.pop_front());
					end
				end else if (pending_q.size() != 0
						&& (calm() || $urandom_range(0, 99) >= 25)) begin
					next_valid = 1'b1;
					next_kind = pending_q[0].kind;
					next_value = pending_q[0].value;
					void'(pending_q.pop_front());
				end
				in_ch.valid <= next_valid;
				in_ch.kind <= next_kind;
				in_ch.value <= next_value;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : sink_p
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_accepted >= HOLD_AT) begin
			out_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ch.ready <= calm() || $urandom_range(0, 99) >= 25;
		end
	end

	always @(posedge clk) begin : check_p
		stack_view_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (view_q.size() == 0) begin
				$display("%0t: unexpected item top_value %h depth %0d status %0d", $time,
					out_ch.top_value, out_ch.depth, out_ch.status);
				errors++;
			end else begin
				want = view_q.pop_front();
				if (out_ch.top_value !== want.top_value) begin
					$display("%0t: top_value expected %h got %h", $time,
						want.top_value, out_ch.top_value);
					errors++;
				end
				if (out_ch.depth !== want.depth) begin
					$display("%0t: depth expected %0d got %0d", $time,
						want.depth, out_ch.depth);
					errors++;
				end
				if (out_ch.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, out_ch.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin : limit_p
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[stack_machine_alu] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = OP_PUSH;
		in_ch.value = '0;
		out_ch.ready = 1'b0;
		stack_cnt = 0;
		errors = 0;
		cycles = 0;

		queue_op(OP_ADD, data_t'(32'h5555_aaaa));
		queue_op(OP_NEG, '0);
		queue_op(OP_DUP, '0);
		queue_op(OP_MIN, '0);
		queue_op(OP_PUSH, data_t'(-1));
		queue_op(OP_SWAP, '0);
		queue_op(OP_DIV, '0);
		queue_op(OP_PUSH, data_t'(32'h8000_0000));
		queue_op(OP_DIV, '0);
		queue_op(OP_NEG, '0);
		queue_op(OP_PUSH, '0);
		queue_op(OP_SWAP, '0);
		queue_op(OP_DIV, data_t'(-1));
		queue_op(OP_PUSH, data_t'(32'h7fff_ffff));
		queue_op(OP_DUP, '0);
		queue_op(OP_ADD, '0);
		queue_op(OP_MUL, '0);
		queue_op(OP_PUSH, data_t'(-7));
		queue_op(OP_SUB, '0);
		queue_op(OP_PUSH, data_t'(3));
		queue_op(OP_MAX, '0);
		queue_op(OP_PUSH, data_t'(-3));
		queue_op(OP_MIN, '0);
		for (int k = 10; k < 16; k++) begin
			queue_op(kind_t'(k), pick_value());
		end
		queue_random_ops(250);
		queue_random_ops(250);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_q.size() != 0 || in_ch.valid || view_q.size() != 0);

		queue_random_ops(80);

		do @(posedge clk);
		while (pending_q.size() != 0 || in_ch.valid);
		while (view_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && view_q.size() == 0) begin
			$display("[stack_machine_alu] OK");
		end else begin
			$display("[stack_machine_alu] ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/sma_pkg.sv
hw/rtl/sma_if.sv
hw/rtl/sma_div.sv
hw/rtl/sma_dp.sv
hw/rtl/sma_ctrl.sv
hw/rtl/stack_machine_alu.sv
hw/rtl/sma_check.sv
sim/tb_stack_machine_alu.sv
